@@ src/bfd_pkg.sv @@
`default_nettype none

package bfd_pkg;

  // accumulator width per channel
  localparam int unsigned SUM_W = 20;
  // output queue depth
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_AW = 2;
  localparam int unsigned OUT_CW = 3;

  typedef enum logic [2:0] {
    CFG_FOUR_CH  = 3'd0,
    CFG_SCALE    = 3'd1,
    CFG_ROUND    = 3'd2,
    CFG_SHIFT    = 3'd3,
    CFG_DST_W    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] sample0;
    logic [7:0] sample1;
    logic [7:0] sample2;
    logic [7:0] sample3;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
    logic [7:0] out3;
    logic [9:0] dest_column;
    logic       row_end;
  } out_beat_t;

  // per-beat control seen by every lane in the accumulate stage
  typedef struct packed {
    logic valid;
    logic first;
    logic fwd;
  } lane_ctrl_t;

endpackage

`default_nettype wire

@@ src/bfd_sum_ram.sv @@
`default_nettype none

module bfd_sum_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned WIDTH = 80
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/bfd_lane.sv @@
`default_nettype none

module bfd_lane (
  input  wire logic                       clk_i,
  input  wire bfd_pkg::lane_ctrl_t        ctrl_i,
  input  wire logic [7:0]                 sample_i,
  input  wire logic [bfd_pkg::SUM_W-1:0]  rd_i,
  input  wire logic [11:0]                offset_i,
  input  wire logic [3:0]                 shift_i,
  input  wire logic                       active_i,
  output logic      [bfd_pkg::SUM_W-1:0]  sum_o,
  output logic      [7:0]                 val_o
);
  import bfd_pkg::*;

  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] base;
  logic [SUM_W:0]   rounded;
  logic [SUM_W:0]   shifted;

  // accumulate stage, newest sum is forwarded when the ram has not seen it yet
  always_comb begin
    if (ctrl_i.first) begin
      base = '0;
    end else if (ctrl_i.fwd) begin
      base = sum_q;
    end else begin
      base = rd_i;
    end
    sum_o = base + {{(SUM_W-8){1'b0}}, sample_i};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      sum_q <= sum_o;
    end
  end

  // round, shift, saturate; an inactive lane outputs zero
  always_comb begin
    rounded = {1'b0, sum_q} + {{(SUM_W+1-12){1'b0}}, offset_i};
    shifted = rounded >> shift_i;
    if (!active_i) begin
      val_o = '0;
    end else if (|shifted[SUM_W:8]) begin
      val_o = 8'hff;
    end else begin
      val_o = shifted[7:0];
    end
  end

endmodule

`default_nettype wire

@@ src/bfd_merge.sv @@
`default_nettype none

module bfd_merge (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire logic [3:0][7:0]             lane_val_i,
  input  wire logic [9:0]                  dest_column_i,
  input  wire logic                        row_end_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output bfd_pkg::out_beat_t               out_beat_o,
  output logic      [bfd_pkg::OUT_CW-1:0]  count_o
);
  import bfd_pkg::*;

  out_beat_t         buf_q [OUT_DEPTH];
  out_beat_t         beat_d;
  logic [OUT_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CW-1:0] count_q;
  logic              pop;

  always_comb begin
    beat_d.out0        = lane_val_i[0];
    beat_d.out1        = lane_val_i[1];
    beat_d.out2        = lane_val_i[2];
    beat_d.out3        = lane_val_i[3];
    beat_d.dest_column = dest_column_i;
    beat_d.row_end     = row_end_i;
  end

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_beat_o  = buf_q[rd_ptr_q];
  assign count_o     = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= beat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OUT_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_AW'(1);
      end
      if (push_i && !pop) begin
        count_q <= count_q + OUT_CW'(1);
      end else if (pop && !push_i) begin
        count_q <= count_q - OUT_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/box_filter_downsample_unit.sv @@
`default_nettype none
// box filter downscale: one source pixel accepted per clock while in_ready_o is high
// result path: the bottom-right pixel of a block is read from the ram, accumulated
//   and rounded, and its result beat is then pushed into the output queue
// the column-sum ram does one read and one write per clock,
//   with the newest sum forwarded around the ram on back-to-back column hits
// reset: config returns to its defaults, then all MAX_DEST_WIDTH column-sum ram
//   entries are cleared with in_ready_o low; config writes are taken meanwhile

module box_filter_downsample_unit #(
  parameter int unsigned MAX_DEST_WIDTH = 1024,
  parameter int unsigned MAX_SCALE      = 64,
  parameter int unsigned CHANNELS       = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [11:0]         cfg_data_i,
  // source pixels
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bfd_pkg::in_beat_t   in_beat_i,
  // destination pixels
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output bfd_pkg::out_beat_t       out_beat_o
);
  import bfd_pkg::*;

  // column index, block counter, clamped-limit and ram row widths
  localparam int unsigned CW  = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;
  localparam int unsigned WW1 = $clog2(MAX_DEST_WIDTH + 1);
  localparam int unsigned SW  = $clog2(MAX_SCALE);
  localparam int unsigned SW1 = $clog2(MAX_SCALE + 1);
  localparam int unsigned RW  = CHANNELS * SUM_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic        four_q;
  logic [6:0]  scale_q;
  logic [11:0] round_q;
  logic [3:0]  shift_q;
  logic [10:0] dst_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_q  <= 1'b1;
      scale_q <= 7'd2;
      round_q <= 12'd2;
      shift_q <= 4'd2;
      dst_w_q <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FOUR_CH: four_q  <= cfg_data_i[0];
        CFG_SCALE:   scale_q <= cfg_data_i[6:0];
        CFG_ROUND:   round_q <= cfg_data_i;
        CFG_SHIFT:   shift_q <= cfg_data_i[3:0];
        CFG_DST_W:   dst_w_q <= cfg_data_i[10:0];
        default: begin
        end
      endcase
    end
  end

  // clamp scale and width into the supported range
  logic [SW1-1:0] eff_scale;
  logic [WW1-1:0] eff_width;

  always_comb begin
    if ({25'd0, scale_q} < 32'd2) begin
      eff_scale = SW1'(2);
    end else if ({25'd0, scale_q} > 32'(MAX_SCALE)) begin
      eff_scale = SW1'(MAX_SCALE);
    end else begin
      eff_scale = SW1'(scale_q);
    end
    if (dst_w_q == '0) begin
      eff_width = WW1'(1);
    end else if ({21'd0, dst_w_q} > 32'(MAX_DEST_WIDTH)) begin
      eff_width = WW1'(MAX_DEST_WIDTH);
    end else begin
      eff_width = WW1'(dst_w_q);
    end
  end

  // ---------------------------------------------------------------------------
  // ram clearing pass after reset
  // ---------------------------------------------------------------------------
  logic          clearing_q;
  logic [CW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + CW'(1);
      if (clr_addr_q == CW'(MAX_DEST_WIDTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // position counters, evaluated for the pixel on the input port
  // ---------------------------------------------------------------------------
  logic [SW-1:0] row_q, col_q;
  logic [CW-1:0] dcol_q;
  logic          first, last_col, last_row, row_last_dest, emit;
  logic          in_fire;

  assign first         = (row_q == '0) && (col_q == '0);
  assign last_col      = (SW1'(col_q) + SW1'(1)) >= eff_scale;
  assign last_row      = (SW1'(row_q) + SW1'(1)) >= eff_scale;
  assign row_last_dest = (WW1'(dcol_q) + WW1'(1)) >= eff_width;
  assign emit          = last_col && last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      dcol_q <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_q <= '0;
        if (row_last_dest) begin
          dcol_q <= '0;
          row_q  <= last_row ? '0 : row_q + SW'(1);
        end else begin
          dcol_q <= dcol_q + CW'(1);
        end
      end else begin
        col_q <= col_q + SW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // accumulate stage (s1): ram data arrives, lanes add the new samples
  // ---------------------------------------------------------------------------
  logic          s1_valid_q, s1_emit_q, s1_first_q, s1_fwd_q, s1_rend_q;
  logic [CW-1:0] s1_addr_q;
  logic [3:0][7:0] s1_smp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      s1_emit_q  <= in_fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_first_q  <= first;
      // the beat ahead writes this column at the same edge this one reads it
      s1_fwd_q    <= s1_valid_q && (s1_addr_q == dcol_q);
      s1_rend_q   <= row_last_dest;
      s1_addr_q   <= dcol_q;
      s1_smp_q[0] <= in_beat_i.sample0;
      s1_smp_q[1] <= four_q ? in_beat_i.sample1 : 8'd0;
      s1_smp_q[2] <= four_q ? in_beat_i.sample2 : 8'd0;
      s1_smp_q[3] <= four_q ? in_beat_i.sample3 : 8'd0;
    end
  end

  // ---------------------------------------------------------------------------
  // column-sum ram, one row of CHANNELS sums per destination column
  // ---------------------------------------------------------------------------
  logic [RW-1:0] ram_rdata, ram_wdata, lane_wdata;
  logic          ram_we;
  logic [CW-1:0] ram_waddr;

  assign ram_we    = clearing_q || s1_valid_q;
  assign ram_waddr = clearing_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clearing_q ? '0 : lane_wdata;

  bfd_sum_ram #(
    .DEPTH (MAX_DEST_WIDTH),
    .AW    (CW),
    .WIDTH (RW)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (dcol_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // channel lanes
  // ---------------------------------------------------------------------------
  lane_ctrl_t      lane_ctrl;
  logic [3:0][7:0] lane_val;

  assign lane_ctrl.valid = s1_valid_q;
  assign lane_ctrl.first = s1_first_q;
  assign lane_ctrl.fwd   = s1_fwd_q;

  for (genvar c = 0; c < 4; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      bfd_lane u_lane (
        .clk_i    (clk_i),
        .ctrl_i   (lane_ctrl),
        .sample_i (s1_smp_q[c]),
        .rd_i     (ram_rdata[c*SUM_W +: SUM_W]),
        .offset_i (round_q),
        .shift_i  (shift_q),
        .active_i ((c == 0) || four_q),
        .sum_o    (lane_wdata[c*SUM_W +: SUM_W]),
        .val_o    (lane_val[c])
      );
    end else begin : g_off
      assign lane_val[c] = 8'd0;
    end
  end

  // ---------------------------------------------------------------------------
  // round stage (s2) metadata and merge into the output queue
  // ---------------------------------------------------------------------------
  logic          s2_emit_q, s2_rend_q;
  logic [CW-1:0] s2_col_q;
  logic [OUT_CW-1:0] q_count;
  logic [OUT_CW:0]   reserved;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_emit_q <= 1'b0;
    end else begin
      s2_emit_q <= s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_col_q  <= s1_addr_q;
      s2_rend_q <= s1_rend_q;
    end
  end

  bfd_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (s2_emit_q),
    .lane_val_i    (lane_val),
    .dest_column_i (10'(s2_col_q)),
    .row_end_i     (s2_rend_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_beat_o    (out_beat_o),
    .count_o       (q_count)
  );

  // every result in flight owns a queue slot, so the pipe never has to stall
  assign reserved   = {1'b0, q_count} + (OUT_CW+1)'(s1_emit_q) + (OUT_CW+1)'(s2_emit_q);
  assign in_ready_o = !clearing_q && (reserved < (OUT_CW+1)'(OUT_DEPTH));
  assign in_fire    = in_valid_i && in_ready_o;

endmodule

`default_nettype wire
